// File: rtl/swl_pkg.sv
// Stopwatch package: opcode enum, timing constants, reciprocal constants and
// the snapshot/result structs shared by the stopwatch modules and interfaces.
// No dependencies.
package swl_pkg;

  localparam int unsigned MS_W     = 29;
  localparam int unsigned LAPCNT_W = 16;
  localparam int unsigned EL_W     = 16;
  localparam int unsigned OP_W     = 4;
  localparam int unsigned QS_W     = 19;  // whole seconds, below 360000
  localparam int unsigned QM_W     = 13;  // whole minutes, below 6000
  localparam int unsigned LAPS_SHOWN = 3;

  typedef logic [MS_W-1:0] ms_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 4'd0,
    OP_TOGGLE     = 4'd1,
    OP_LAP        = 4'd2,
    OP_CLEAR      = 4'd3,
    OP_ALM_HR_UP  = 4'd4,
    OP_ALM_HR_DN  = 4'd5,
    OP_ALM_MIN_UP = 4'd6,
    OP_ALM_MIN_DN = 4'd7,
    OP_ALM_SEC_UP = 4'd8,
    OP_ALM_SEC_DN = 4'd9
  } op_e;

  localparam ms_t TIME_LIMIT  = 29'd359999999;
  localparam ms_t ALARM_MIN   = 29'd1000;
  localparam ms_t ALARM_RESET = 29'd25000;
  localparam ms_t MS_PER_HOUR = 29'd3600000;
  localparam ms_t MS_PER_MIN  = 29'd60000;
  localparam ms_t MS_PER_SEC  = 29'd1000;
  localparam logic [LAPCNT_W-1:0] LAP_MAX = 16'hFFFF;
  localparam logic [5:0] SIXTY = 6'd60;

  // floor(x / d) == (x * RCP) >> SH over the value range of each stage
  localparam logic [28:0] RCP_SEC = 29'd274877907;  // /1000, x < 2^29
  localparam int unsigned SH_SEC  = 38;
  localparam logic [19:0] RCP_MIN = 20'd559241;     // /60,   x < 360000
  localparam int unsigned SH_MIN  = 25;
  localparam logic [13:0] RCP_HR  = 14'd8739;       // /60,   x < 6000
  localparam int unsigned SH_HR   = 19;
  localparam logic [9:0]  RCP_CS  = 10'd820;        // /10,   x < 1000
  localparam int unsigned SH_CS   = 13;

  typedef struct packed {
    ms_t                 time_ms;
    logic                running;
    logic                alarm_active;
    ms_t                 alarm_ms;
    logic [LAPCNT_W-1:0] laps_taken;
    ms_t                 lap_newest;
    ms_t                 lap_middle;
    ms_t                 lap_oldest;
  } snap_t;

  typedef struct packed {
    snap_t      snap;
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [6:0] hundredths;
  } res_t;

endpackage

// File: rtl/swl_in_if.sv
// Input channel of the stopwatch: valid/ready handshake with opcode and tick.
// Depends on swl_pkg.
interface swl_in_if import swl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] opcode;
  logic [EL_W-1:0] elapsed_ms;

  modport source (output valid, output opcode, output elapsed_ms, input ready);
  modport sink   (input valid, input opcode, input elapsed_ms, output ready);
endinterface

// File: rtl/swl_out_if.sv
// Result channel of the stopwatch: valid/ready handshake with time split,
// alarm and lap fields. Depends on swl_pkg.
interface swl_out_if import swl_pkg::*; ();
  logic                valid;
  logic                ready;
  ms_t                 time_ms;
  logic [6:0]          hours;
  logic [5:0]          minutes;
  logic [5:0]          seconds;
  logic [6:0]          hundredths;
  logic                running;
  logic                alarm_active;
  ms_t                 alarm_ms;
  logic [LAPCNT_W-1:0] laps_taken;
  ms_t                 lap_newest;
  ms_t                 lap_middle;
  ms_t                 lap_oldest;

  modport source (output valid, output time_ms, output hours, output minutes,
                  output seconds, output hundredths, output running,
                  output alarm_active, output alarm_ms, output laps_taken,
                  output lap_newest, output lap_middle, output lap_oldest,
                  input ready);
  modport sink   (input valid, input time_ms, input hours, input minutes,
                  input seconds, input hundredths, input running,
                  input alarm_active, input alarm_ms, input laps_taken,
                  input lap_newest, input lap_middle, input lap_oldest,
                  output ready);
endinterface

// File: rtl/swl_state.sv
// Stopwatch state: run flag, time count, alarm, lap store and lap count,
// updated once per accepted word; emits the post-update snapshot. Uses swl_pkg.
module swl_state import swl_pkg::*; #(
  parameter int unsigned LAP_SLOTS = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [OP_W-1:0] opcode_i,
  input  logic [EL_W-1:0] elapsed_ms_i,
  output logic            snap_valid_o,
  input  logic            snap_ready_i,
  output snap_t           snap_o
);

  logic                run_q, run_d;
  ms_t                 count_q, count_d;
  ms_t                 alarm_q, alarm_d;
  ms_t                 lap_q [LAP_SLOTS];
  ms_t                 lap_d [LAP_SLOTS];
  logic [LAPCNT_W-1:0] total_q, total_d;

  logic        accept;
  op_e         op;
  logic [29:0] tick_sum;
  ms_t         delta;
  logic [29:0] alarm_sum;
  logic [29:0] alarm_dif;
  logic        up_ok, dn_ok;
  ms_t         view [LAPS_SHOWN];

  assign ready_o      = snap_ready_i;
  assign snap_valid_o = valid_i;
  assign accept       = valid_i && snap_ready_i;
  assign op           = op_e'(opcode_i);

  assign tick_sum = {1'b0, count_q} + 30'(elapsed_ms_i);

  always_comb begin
    case (op) inside
      OP_ALM_HR_UP, OP_ALM_HR_DN:   delta = MS_PER_HOUR;
      OP_ALM_MIN_UP, OP_ALM_MIN_DN: delta = MS_PER_MIN;
      default:                      delta = MS_PER_SEC;
    endcase
  end

  assign alarm_sum = {1'b0, alarm_q} + {1'b0, delta};
  assign alarm_dif = {1'b0, alarm_q} - {1'b0, delta};
  assign up_ok     = alarm_sum <= {1'b0, TIME_LIMIT};
  assign dn_ok     = !alarm_dif[29] && (alarm_dif[28:0] >= ALARM_MIN);

  always_comb begin
    run_d   = run_q;
    count_d = count_q;
    alarm_d = alarm_q;
    total_d = total_q;
    for (int i = 0; i < LAP_SLOTS; i++) lap_d[i] = lap_q[i];
    unique case (op) inside
      OP_TICK: begin
        if (run_q) begin
          count_d = (tick_sum >= {1'b0, TIME_LIMIT}) ? '0 : tick_sum[28:0];
        end
      end
      OP_TOGGLE: run_d = !run_q;
      OP_LAP: begin
        for (int i = LAP_SLOTS - 1; i > 0; i--) lap_d[i] = lap_q[i-1];
        lap_d[0] = count_q;
        if (total_q != LAP_MAX) total_d = total_q + 1'b1;
      end
      OP_CLEAR: begin
        run_d   = 1'b0;
        count_d = '0;
        total_d = '0;
        for (int i = 0; i < LAP_SLOTS; i++) lap_d[i] = '0;
      end
      OP_ALM_HR_UP, OP_ALM_MIN_UP, OP_ALM_SEC_UP: begin
        if (up_ok) alarm_d = alarm_sum[28:0];
      end
      OP_ALM_HR_DN, OP_ALM_MIN_DN, OP_ALM_SEC_DN: begin
        if (dn_ok) alarm_d = alarm_dif[28:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      count_q <= '0;
      alarm_q <= ALARM_RESET;
      total_q <= '0;
      for (int i = 0; i < LAP_SLOTS; i++) lap_q[i] <= '0;
    end else if (accept) begin
      run_q   <= run_d;
      count_q <= count_d;
      alarm_q <= alarm_d;
      total_q <= total_d;
      for (int i = 0; i < LAP_SLOTS; i++) lap_q[i] <= lap_d[i];
    end
  end

  // slots beyond LAP_SLOTS read as zero
  for (genvar g = 0; g < LAPS_SHOWN; g++) begin : g_view
    if (g < LAP_SLOTS) begin : g_slot
      assign view[g] = lap_d[g];
    end else begin : g_none
      assign view[g] = '0;
    end
  end

  always_comb begin
    snap_o.time_ms      = count_d;
    snap_o.running      = run_d;
    snap_o.alarm_active = (alarm_d <= count_d) &&
                          ({1'b0, count_d} <= ({1'b0, alarm_d} + {1'b0, MS_PER_SEC}));
    snap_o.alarm_ms     = alarm_d;
    snap_o.laps_taken   = total_d;
    snap_o.lap_newest   = view[0];
    snap_o.lap_middle   = view[1];
    snap_o.lap_oldest   = view[2];
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < TIME_LIMIT)
    else $error("time count out of range");

  a_alarm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alarm_q >= ALARM_MIN) && (alarm_q <= TIME_LIMIT))
    else $error("alarm out of range");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == OP_CLEAR) |=> !run_q && (count_q == '0) && (total_q == '0))
    else $error("clear left run state behind");

  a_stopped_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == OP_TICK) && !run_q |=> $stable(count_q))
    else $error("time moved while stopped");
`endif

endmodule

// File: rtl/swl_split.sv
// Five-stage pipeline that splits the time into hours, minutes, seconds and
// hundredths by reciprocal multiplication. Uses swl_pkg.
module swl_split import swl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  snap_t snap_i,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  res_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  snap_t            s1_q, s2_q, s3_q, s4_q, s5_q;
  logic [QS_W-1:0]  qs2_q, qs3_q;
  logic [QM_W-1:0]  qm3_q, qm4_q;
  logic [9:0]       rms3_q;
  logic [5:0]       sec4_q, sec5_q;
  logic [6:0]       cs4_q, cs5_q;
  logic [6:0]       hr4_q, hr5_q;
  logic [5:0]       min5_q;

  logic [57:0]      p_sec;
  logic [38:0]      p_min;
  ms_t              qs_ms;
  ms_t              rms_full;
  logic [QS_W-1:0]  qm_x60;
  logic [QS_W-1:0]  sec_full;
  logic [19:0]      p_cs;
  logic [26:0]      p_hr;
  logic [QM_W-1:0]  hr_x60;
  logic [QM_W-1:0]  min_full;

  function automatic ms_t MS_t_mul(input logic [QS_W-1:0] q);
    return ms_t'(q) * MS_PER_SEC;
  endfunction

  // a stage takes a new word when it is empty or its successor moves
  assign rdy5    = !v5_q || ready_i;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  assign p_sec    = 58'(s1_q.time_ms) * 58'(RCP_SEC);
  assign p_min    = 39'(qs2_q) * 39'(RCP_MIN);
  assign qs_ms    = MS_t_mul(qs2_q);
  assign rms_full = s2_q.time_ms - qs_ms;
  assign qm_x60   = 19'(qm3_q) * 19'(SIXTY);
  assign sec_full = qs3_q - qm_x60;
  assign p_cs     = 20'(rms3_q) * 20'(RCP_CS);
  assign p_hr     = 27'(qm3_q) * 27'(RCP_HR);
  assign hr_x60   = 13'(hr4_q) * 13'(SIXTY);
  assign min_full = qm4_q - hr_x60;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      s1_q <= snap_i;
    end
    if (rdy2 && v1_q) begin
      s2_q  <= s1_q;
      qs2_q <= p_sec[SH_SEC+QS_W-1:SH_SEC];
    end
    if (rdy3 && v2_q) begin
      s3_q   <= s2_q;
      qs3_q  <= qs2_q;
      qm3_q  <= p_min[SH_MIN+QM_W-1:SH_MIN];
      rms3_q <= rms_full[9:0];
    end
    if (rdy4 && v3_q) begin
      s4_q   <= s3_q;
      qm4_q  <= qm3_q;
      sec4_q <= sec_full[5:0];
      cs4_q  <= p_cs[SH_CS+6:SH_CS];
      hr4_q  <= p_hr[SH_HR+6:SH_HR];
    end
    if (rdy5 && v4_q) begin
      s5_q   <= s4_q;
      sec5_q <= sec4_q;
      cs5_q  <= cs4_q;
      hr5_q  <= hr4_q;
      min5_q <= min_full[5:0];
    end
  end

  assign valid_o          = v5_q;
  assign res_o.snap       = s5_q;
  assign res_o.hours      = hr5_q;
  assign res_o.minutes    = min5_q;
  assign res_o.seconds    = sec5_q;
  assign res_o.hundredths = cs5_q;

`ifndef SYNTHESIS
  a_recombine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (36'(hr5_q) * 36'd3600000 + 36'(min5_q) * 36'd60000 +
                 36'(sec5_q) * 36'd1000 + 36'(cs5_q) * 36'd10 <= 36'(s5_q.time_ms)) &&
                (36'(s5_q.time_ms) < 36'(hr5_q) * 36'd3600000 + 36'(min5_q) * 36'd60000 +
                 36'(sec5_q) * 36'd1000 + 36'(cs5_q) * 36'd10 + 36'd10))
    else $error("time split does not add up");

  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (min5_q < SIXTY) && (sec5_q < SIXTY) && (cs5_q < 7'd100))
    else $error("split field out of range");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> v1_q && (s1_q == $past(snap_i)))
    else $error("accepted word not captured");
`endif

endmodule

// File: rtl/stopwatch_with_laps_and_alarm.sv
// Stopwatch top level: state update and time split pipeline behind
// valid/ready channels. Uses swl_pkg, swl_in_if, swl_out_if, swl_state, swl_split.
//
//   channel  | dir | payload
//   ---------+-----+-----------------------------------------------------
//   in_i     | in  | opcode, elapsed_ms
//   out_o    | out | time split, running, alarm flag/time, lap count, laps
//
// One word in per cycle while in_i.ready is high; every word yields one result,
// which passes through the five registered stages of swl_split.
// State (run flag, time, alarm, laps) updates in the cycle of acceptance.
// rst_ni clears state at once: alarm 25000 ms, everything else zero.
// Stalls on out_o fill the pipeline stages first; in_i.ready drops only
// when all five stages hold words.
module stopwatch_with_laps_and_alarm import swl_pkg::*; #(
  parameter int unsigned LAP_SLOTS = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swl_in_if.sink    in_i,
  swl_out_if.source out_o
);

  logic  snap_valid, snap_ready;
  snap_t snap;
  res_t  res;

  swl_state #(
    .LAP_SLOTS (LAP_SLOTS)
  ) u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .opcode_i     (in_i.opcode),
    .elapsed_ms_i (in_i.elapsed_ms),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  swl_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (snap_valid),
    .ready_o (snap_ready),
    .snap_i  (snap),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.time_ms      = res.snap.time_ms;
  assign out_o.hours        = res.hours;
  assign out_o.minutes      = res.minutes;
  assign out_o.seconds      = res.seconds;
  assign out_o.hundredths   = res.hundredths;
  assign out_o.running      = res.snap.running;
  assign out_o.alarm_active = res.snap.alarm_active;
  assign out_o.alarm_ms     = res.snap.alarm_ms;
  assign out_o.laps_taken   = res.snap.laps_taken;
  assign out_o.lap_newest   = res.snap.lap_newest;
  assign out_o.lap_middle   = res.snap.lap_middle;
  assign out_o.lap_oldest   = res.snap.lap_oldest;

endmodule
